// ----- rtl/crp_pkg.sv -----
// Package for the CMOS clock port pair: register index codes, stream field
// layout, read source codes and the small arithmetic helpers.
// Depends on nothing; imported by cmos_rtc_port_pair_top.
package crp_pkg;

	localparam int CRP_STORE_DEPTH = 128;
	localparam int IDX_W           = 7;
	localparam int TDATA_W         = 56;
	localparam int TUSER_W         = 2;

	localparam logic [IDX_W-1:0] IDX_SEC     = 7'h00;
	localparam logic [IDX_W-1:0] IDX_MIN     = 7'h02;
	localparam logic [IDX_W-1:0] IDX_HOUR    = 7'h04;
	localparam logic [IDX_W-1:0] IDX_WDAY    = 7'h06;
	localparam logic [IDX_W-1:0] IDX_MDAY    = 7'h07;
	localparam logic [IDX_W-1:0] IDX_MONTH   = 7'h08;
	localparam logic [IDX_W-1:0] IDX_YEAR    = 7'h09;
	localparam logic [IDX_W-1:0] IDX_A       = 7'h0a;
	localparam logic [IDX_W-1:0] IDX_B       = 7'h0b;
	localparam logic [IDX_W-1:0] IDX_C       = 7'h0c;
	localparam logic [IDX_W-1:0] IDX_D       = 7'h0d;
	localparam logic [IDX_W-1:0] IDX_CENTURY = 7'h32;

	localparam logic [7:0] RST_A     = 8'h26;
	localparam logic [7:0] RST_B     = 8'h02;
	localparam logic [7:0] RST_D     = 8'h80;
	localparam logic [7:0] BYTE_ONES = 8'hff;

	localparam logic FUNC_WRITE = 1'b1;
	localparam logic PORT_DATA  = 1'b1;

	// where a read byte comes from
	typedef enum logic [1:0] {
		SRC_TIME  = 2'd0,
		SRC_ZERO  = 2'd1,
		SRC_STORE = 2'd2,
		SRC_ONES  = 2'd3
	} src_t;

	function automatic logic [7:0] store_rst(input logic [IDX_W-1:0] idx);
		logic [7:0] v;
		unique case (idx)
			IDX_A:   v = RST_A;
			IDX_B:   v = RST_B;
			IDX_D:   v = RST_D;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// value below 100 to packed BCD; tens by reciprocal 205/2048
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p    = 15'(v) * 15'd205;
		tens = p[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	// value below 200 reduced mod 100
	function automatic logic [6:0] mod100_small(input logic [7:0] v);
		logic [7:0] r;
		r = (v >= 8'd100) ? v - 8'd100 : v;
		return r[6:0];
	endfunction

endpackage

// ----- rtl/cmos_rtc_port_pair_top.sv -----
// CMOS clock port pair: index port, data port, 128-byte CMOS store in a
// synchronous RAM with per-entry valid bits, BCD time readout.
// Depends on crp_pkg.
//
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | write_data, now_second..now_year         | func, port
//  m_*     | out | read_data                               | -
//
// A write transfer returns nothing. A read transfer registers the RAM read
// and time-field reduction into stage 1 when it is accepted; the BCD byte
// is loaded into the output register when stage 1 moves on, which can wait
// behind a stalled output.
// Transfers are accepted every cycle unless a read waits in stage 1 behind
// a stalled output. Reset restores the store through valid bits at once.
module cmos_rtc_port_pair_top #(
	parameter int STORE_DEPTH = crp_pkg::CRP_STORE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [7:0] write_data, [13:8] now_second, [19:14] now_minute, [24:20] now_hour,
	// [27:25] now_weekday, [32:28] now_day, [36:33] now_month, [50:37] now_year
	input  logic [crp_pkg::TDATA_W-1:0] s_tdata,
	// [0] func, [1] port
	input  logic [crp_pkg::TUSER_W-1:0] s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [7:0] read_data
	output logic [7:0]                 m_tdata
);
	import crp_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [7:0]  write_data;
	logic [5:0]  now_second, now_minute;
	logic [4:0]  now_hour, now_day;
	logic [2:0]  now_weekday;
	logic [3:0]  now_month;
	logic [13:0] now_year;
	logic        func, port;

	assign write_data  = s_tdata[7:0];
	assign now_second  = s_tdata[13:8];
	assign now_minute  = s_tdata[19:14];
	assign now_hour    = s_tdata[24:20];
	assign now_weekday = s_tdata[27:25];
	assign now_day     = s_tdata[32:28];
	assign now_month   = s_tdata[36:33];
	assign now_year    = s_tdata[50:37];
	assign func        = s_tuser[0];
	assign port        = s_tuser[1];

	logic [IDX_W-1:0]       sel_q;
	logic [STORE_DEPTH-1:0] vld_q;
	logic [7:0]             mem [STORE_DEPTH];

	logic       pend_s1;
	src_t       src_s1;
	logic [7:0] rd_s1;
	logic       vld_s1;
	logic [7:0] rst_s1;
	logic [6:0] tval_s1;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	logic            acc, acc_rd, acc_wr_data, move_s1, in_range, wr_ok;
	logic [AW-1:0]   addr;
	src_t            src_d;
	logic [6:0]      tval_d;
	logic [26:0]     yr_p;
	logic [7:0]      yr_q100;
	logic [13:0]     yr_rem;
	logic [7:0]      rd_byte;

	assign move_s1  = pend_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !pend_s1 || move_s1;
	assign acc      = s_tvalid && s_tready;
	assign acc_rd   = acc && (func != FUNC_WRITE);
	assign acc_wr_data = acc && (func == FUNC_WRITE) && (port == PORT_DATA);

	assign in_range = {1'b0, sel_q} < (IDX_W+1)'(STORE_DEPTH);
	assign addr     = AW'(sel_q);
	assign wr_ok    = acc_wr_data && in_range && (sel_q != IDX_C) && (sel_q != IDX_D);

	// year / 100 by reciprocal 5243/2^19, exact below 43690
	always_comb begin
		yr_p    = 27'(now_year) * 27'd5243;
		yr_q100 = yr_p[26:19];
		yr_rem  = now_year - ({6'd0, yr_q100} << 6) - ({6'd0, yr_q100} << 5)
			- ({6'd0, yr_q100} << 2);
	end

	always_comb begin
		tval_d = 7'd0;
		case (sel_q)
			IDX_SEC:     tval_d = 7'(now_second);
			IDX_MIN:     tval_d = 7'(now_minute);
			IDX_HOUR:    tval_d = 7'(now_hour);
			IDX_WDAY:    tval_d = 7'(now_weekday) + 7'd1;
			IDX_MDAY:    tval_d = 7'(now_day);
			IDX_MONTH:   tval_d = 7'(now_month) + 7'd1;
			IDX_YEAR:    tval_d = yr_rem[6:0];
			IDX_CENTURY: tval_d = mod100_small(yr_q100);
			default:     tval_d = 7'd0;
		endcase
	end

	always_comb begin
		if (port != PORT_DATA) begin
			src_d = SRC_ONES;
		end else begin
			case (sel_q) inside
				IDX_SEC, IDX_MIN, IDX_HOUR, IDX_WDAY, IDX_MDAY, IDX_MONTH, IDX_YEAR,
				IDX_CENTURY: src_d = SRC_TIME;
				IDX_C:       src_d = SRC_ZERO;
				default:     src_d = in_range ? SRC_STORE : SRC_ONES;
			endcase
		end
	end

	// CMOS store RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[addr] <= write_data;
		end
		if (acc_rd && in_range) begin
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= '0;
			vld_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (acc && (func == FUNC_WRITE) && (port != PORT_DATA)) begin
				sel_q <= write_data[6:0];
			end
			if (wr_ok) begin
				vld_q[addr] <= 1'b1;
			end
			if (acc_rd) begin
				pend_s1 <= 1'b1;
			end else if (move_s1) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rd) begin
			src_s1  <= src_d;
			tval_s1 <= tval_d;
			rst_s1  <= store_rst(sel_q);
			vld_s1  <= in_range ? vld_q[addr] : 1'b0;
		end
	end

	always_comb begin
		unique case (src_s1)
			SRC_TIME:  rd_byte = to_bcd(tval_s1);
			SRC_ZERO:  rd_byte = 8'h00;
			SRC_STORE: rd_byte = vld_s1 ? rd_s1 : rst_s1;
			SRC_ONES:  rd_byte = BYTE_ONES;
			default:   rd_byte = BYTE_ONES;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (move_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			m_tdata_q <= rd_byte;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_rd_pends: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rd |=> pend_s1)
		else $error("read transfer did not enter stage 1");

	a_wr_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == FUNC_WRITE) |=> !pend_s1)
		else $error("write transfer left a pending result");

	a_cd_protected: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_wr_data && (sel_q == IDX_C || sel_q == IDX_D)) |=> $stable(vld_q))
		else $error("write to status C or D reached the store");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && !move_s1) |=> pend_s1 && $stable(src_s1) && $stable(tval_s1))
		else $error("stalled read in stage 1 changed");

endmodule
